/* rtl/gds_pkg.sv */
// gds_pkg: types, constants and step functions for the gamepad deadzone scaler
// no dependencies; used by gamepad_deadzone_scaler and its testbench
`timescale 1ns / 1ps
package gds_pkg;

   localparam logic [14:0] LEFT_STICK_DZ_RESET  = 15'd7849;
   localparam logic [14:0] RIGHT_STICK_DZ_RESET = 15'd8689;
   localparam logic [7:0]  LEFT_TRIG_DZ_RESET   = 8'd30;
   localparam logic [7:0]  RIGHT_TRIG_DZ_RESET  = 8'd30;
   localparam logic [14:0] FULL_STICK   = 15'd32767;
   localparam logic [7:0]  FULL_TRIGGER = 8'd255;
   localparam logic [15:0] Q_MAX        = 16'd32767;

   localparam int SQRT_STAGES = 8;
   localparam int DIV_STEPS   = 15;
   localparam int ST_CAPTURE  = 0;
   localparam int ST_SQUARE   = 1;
   localparam int ST_SQRT0    = 2;
   localparam int ST_SCALE    = ST_SQRT0 + SQRT_STAGES;
   localparam int ST_SAT      = ST_SCALE + 1;
   localparam int ST_DIV0     = ST_SAT + 1;
   localparam int N_STAGES    = ST_DIV0 + DIV_STEPS;

   typedef enum logic [1:0] {
      CSR_LEFT_STICK_DZ  = 2'd0,
      CSR_RIGHT_STICK_DZ = 2'd1,
      CSR_LEFT_TRIG_DZ   = 2'd2,
      CSR_RIGHT_TRIG_DZ  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_LEFT_STICK  = 2'd0,
      KIND_RIGHT_STICK = 2'd1,
      KIND_LEFT_TRIG   = 2'd2,
      KIND_RIGHT_TRIG  = 2'd3
   } kind_type;

   localparam logic [2:0] ID_LEFT_X    = 3'd0;
   localparam logic [2:0] ID_RIGHT_X   = 3'd2;
   localparam logic [2:0] ID_LEFT_TRIG = 3'd4;
   localparam logic [2:0] ID_RIGHT_TRIG = 3'd5;

   typedef struct packed {
      logic        trig;
      logic [2:0]  base_id;
      logic        neg_x;
      logic        neg_y;
      logic        kill;
      logic [16:0] ax;
      logic [16:0] ay;
      logic [7:0]  lvl;
      logic [14:0] dz;
      logic [31:0] v;
      logic [31:0] res;
      logic [46:0] rem_x;
      logic [46:0] rem_y;
      logic [30:0] den;
      logic        sat_x;
      logic        sat_y;
      logic [14:0] q_x;
      logic [14:0] q_y;
   } pipe_type;

   typedef struct packed {
      logic [2:0]  base_id;
      logic [15:0] val_x;
      logic [15:0] val_y;
      logic [1:0]  pend;
   } out_type;

   // one bit of the integer square root
   function automatic pipe_type sqrt_step(pipe_type p, int bit_pos);
      logic [31:0] b;
      pipe_type    r;
      b = 32'd1 << bit_pos;
      r = p;
      if (p.v >= p.res + b) begin
         r.v   = p.v - (p.res + b);
         r.res = (p.res >> 1) + b;
      end else begin
         r.res = p.res >> 1;
      end
      return r;
   endfunction

   // one quotient bit for both lanes
   function automatic pipe_type div_step(pipe_type p, int k);
      logic [46:0] d;
      pipe_type    r;
      d = {16'd0, p.den} << k;
      r = p;
      if (!p.sat_x && p.rem_x >= d) begin
         r.rem_x  = p.rem_x - d;
         r.q_x[k] = 1'b1;
      end
      if (!p.sat_y && p.rem_y >= d) begin
         r.rem_y  = p.rem_y - d;
         r.q_y[k] = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [15:0] apply_sign(logic neg, logic sat, logic [14:0] q);
      logic [15:0] m;
      m = sat ? Q_MAX : {1'b0, q};
      return neg ? 16'(-m) : m;
   endfunction

endpackage

/* rtl/gamepad_deadzone_scaler.sv */
// gamepad_deadzone_scaler: top level, radial stick deadzone and trigger scaling
// depends on gds_pkg
`timescale 1ns / 1ps
// One reading enters per cycle, when req_stall is low, and leaves through a
// one-entry output register. Stick readings go through a squaring stage, eight
// square root stages of two bits each, a scaling multiply and a saturation
// check, then fifteen divider stages with one quotient bit each, X and Y side
// by side; triggers share the X lane. A reading that gives two events holds the
// output register for two transfers, so with rsp_stall low the pipeline takes
// one reading per cycle for single-event or silent readings, and holds
// req_stall high while both events of a stick reading are still pending.
module gamepad_deadzone_scaler
   import gds_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic [7:0]         req_trigger_level,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_axis_id,
   output logic signed [15:0] rsp_scaled_value,
   output logic               rsp_last_event,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_data
);

   logic [14:0] lsdz_ff, rsdz_ff;
   logic [7:0]  ltdz_ff, rtdz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lsdz_ff <= LEFT_STICK_DZ_RESET;
         rsdz_ff <= RIGHT_STICK_DZ_RESET;
         ltdz_ff <= LEFT_TRIG_DZ_RESET;
         rtdz_ff <= RIGHT_TRIG_DZ_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_LEFT_STICK_DZ:  lsdz_ff <= csr_data;
            CSR_RIGHT_STICK_DZ: rsdz_ff <= csr_data;
            CSR_LEFT_TRIG_DZ:   ltdz_ff <= csr_data[7:0];
            CSR_RIGHT_TRIG_DZ:  rtdz_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   pipe_type p_ff [N_STAGES];
   pipe_type p_in [N_STAGES];
   logic     v_ff [N_STAGES];
   out_type  out_ff, out_in;
   logic     advance;

   assign advance   = (out_ff.pend == 2'b00) || (!rsp_stall && out_ff.pend != 2'b11);
   assign req_stall = !advance;

   always_comb begin
      pipe_type c;
      pipe_type s;
      logic [14:0] mc;
      logic [14:0] k;
      logic [7:0]  tk;
      logic [15:0] m0;
      c = '0;
      c.trig  = req_kind[1];
      c.neg_x = req_axis_x[15];
      c.neg_y = req_axis_y[15];
      c.ax    = req_axis_x[15] ? 17'(-{req_axis_x[15], req_axis_x}) : {1'b0, req_axis_x};
      c.ay    = req_axis_y[15] ? 17'(-{req_axis_y[15], req_axis_y}) : {1'b0, req_axis_y};
      c.lvl   = req_trigger_level;
      case (kind_type'(req_kind))
         KIND_LEFT_STICK: begin
            c.dz = lsdz_ff;
            c.base_id = ID_LEFT_X;
         end
         KIND_RIGHT_STICK: begin
            c.dz = rsdz_ff;
            c.base_id = ID_RIGHT_X;
         end
         KIND_LEFT_TRIG: begin
            c.dz = {7'd0, ltdz_ff};
            c.base_id = ID_LEFT_TRIG;
         end
         default: begin
            c.dz = {7'd0, rtdz_ff};
            c.base_id = ID_RIGHT_TRIG;
         end
      endcase
      p_in[ST_CAPTURE] = c;

      s = p_ff[ST_CAPTURE];
      s.v   = 32'(s.ax) * 32'(s.ax) + 32'(s.ay) * 32'(s.ay);
      s.res = '0;
      p_in[ST_SQUARE] = s;

      for (int i = 0; i < SQRT_STAGES; i++) begin
         s = p_ff[ST_SQRT0 + i - 1];
         s = sqrt_step(s, 30 - 4 * i);
         s = sqrt_step(s, 28 - 4 * i);
         p_in[ST_SQRT0 + i] = s;
      end

      s  = p_ff[ST_SCALE - 1];
      m0 = s.res[15:0];
      mc = m0[15] ? FULL_STICK : m0[14:0];
      k  = mc - s.dz;
      tk = s.lvl - s.dz[7:0];
      if (s.trig) begin
         s.kill  = (s.lvl <= s.dz[7:0]) || (s.dz[7:0] == FULL_TRIGGER);
         s.neg_x = 1'b0;
         s.neg_y = 1'b0;
         s.rem_x = {24'd0, tk, 15'd0};
         s.rem_y = '0;
         s.den   = {23'd0, 8'(FULL_TRIGGER - s.dz[7:0])};
      end else begin
         s.kill  = ({1'b0, m0} <= {2'b0, s.dz}) || (s.dz == FULL_STICK);
         s.rem_x = {32'(s.ax) * 32'(k), 15'd0};
         s.rem_y = {32'(s.ay) * 32'(k), 15'd0};
         s.den   = 31'(m0) * 31'(15'(FULL_STICK - s.dz));
      end
      p_in[ST_SCALE] = s;

      s = p_ff[ST_SCALE];
      s.sat_x = {1'b0, s.rem_x[46:15]} >= {2'b0, s.den};
      s.sat_y = {1'b0, s.rem_y[46:15]} >= {2'b0, s.den};
      s.q_x   = '0;
      s.q_y   = '0;
      p_in[ST_SAT] = s;

      for (int i = 0; i < DIV_STEPS; i++) begin
         p_in[ST_DIV0 + i] = div_step(p_ff[ST_DIV0 + i - 1], DIV_STEPS - 1 - i);
      end
   end

   always_comb begin
      pipe_type f;
      f = p_ff[N_STAGES - 1];
      out_in.base_id = f.base_id;
      out_in.val_x   = apply_sign(f.neg_x, f.sat_x, f.q_x);
      out_in.val_y   = apply_sign(f.neg_y, f.sat_y, f.q_y);
      out_in.pend[0] = v_ff[N_STAGES - 1] && !f.kill && out_in.val_x != 16'd0;
      out_in.pend[1] = v_ff[N_STAGES - 1] && !f.kill && !f.trig && out_in.val_y != 16'd0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < N_STAGES; i++) p_ff[i] <= p_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_STAGES; i++) v_ff[i] <= 1'b0;
         out_ff.pend <= 2'b00;
      end else if (advance) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i < N_STAGES; i++) v_ff[i] <= v_ff[i - 1];
         out_ff <= out_in;
      end else if (!rsp_stall) begin
         // two pending: first transfer drops the X event
         out_ff.pend <= 2'b10;
      end
   end

   assign rsp_valid        = out_ff.pend != 2'b00;
   assign rsp_axis_id      = out_ff.pend[0] ? out_ff.base_id : out_ff.base_id + 3'd1;
   assign rsp_scaled_value = out_ff.pend[0] ? out_ff.val_x : out_ff.val_y;
   assign rsp_last_event   = out_ff.pend != 2'b11;

endmodule

/* rtl/gds_checker.sv */
// gds_checker: port-level assertions for gamepad_deadzone_scaler, bound to the top
// depends on gamepad_deadzone_scaler
`timescale 1ns / 1ps
module gds_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_axis_id,
   input logic signed [15:0] rsp_scaled_value,
   input logic               rsp_last_event
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_axis_id)
         && $stable(rsp_scaled_value) && $stable(rsp_last_event))
      else $error("stalled transfer changed");

   a_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_axis_id <= 3'd5)
      else $error("axis id out of range");

   a_trig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_axis_id >= 3'd4 |-> rsp_last_event && !rsp_scaled_value[15])
      else $error("trigger event malformed");

   a_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_scaled_value != 16'sd0 && rsp_scaled_value != 16'sh8000)
      else $error("event value out of range");

   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_event |-> !rsp_axis_id[0] && rsp_axis_id < 3'd4)
      else $error("first of two events not an X axis");

endmodule

bind gamepad_deadzone_scaler gds_checker u_gds_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_axis_id(rsp_axis_id),
   .rsp_scaled_value(rsp_scaled_value),
   .rsp_last_event(rsp_last_event)
);

/* dv/tb_gamepad_deadzone_scaler.sv */
// tb_gamepad_deadzone_scaler: self-checking testbench for gamepad_deadzone_scaler
// random stick and trigger readings against an inline predictor; depends on gds_pkg
`timescale 1ns / 1ps
module tb_gamepad_deadzone_scaler;
   import gds_pkg::*;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic [7:0]         lvl;
   } reading_type;

   typedef struct packed {
      logic [2:0]  id;
      logic [15:0] val;
      logic        last;
   } axis_event_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic [1:0] req_kind = 0;
   logic signed [15:0] req_axis_x = 0, req_axis_y = 0;
   logic [7:0] req_trigger_level = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [2:0] rsp_axis_id;
   logic signed [15:0] rsp_scaled_value;
   logic rsp_last_event;
   logic csr_write = 0;
   logic [1:0] csr_index = 0;
   logic [14:0] csr_data = 0;

   reading_type    pending_readings[$];
   axis_event_type expected_events[$];
   logic [14:0] lstick_dz, rstick_dz;
   logic [7:0]  ltrig_dz, rtrig_dz;
   int mismatches = 0;
   int send_gap = 0, recv_gap = 0;
   bit calm = 0, hold = 0;
   bit in_taken = 0;

   gamepad_deadzone_scaler DUT (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] int_sqrt(logic [31:0] v);
      logic [31:0] r, b;
      r = 0;
      b = 32'd1 << 30;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else r = r >> 1;
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] q15(bit neg, longint unsigned num, longint unsigned den);
      longint unsigned q;
      q = (den == 0) ? 0 : num / den;
      if (q > 32767) q = 32767;
      return neg ? 16'(-q) : 16'(q);
   endfunction

   // expected events for one reading
   task automatic predict_events(reading_type r);
      longint unsigned ax, ay, den;
      logic [31:0] m0, mc, dz;
      logic [15:0] vals[2];
      logic [2:0] base;
      axis_event_type e;
      int n;
      if (r.kind == KIND_LEFT_TRIG || r.kind == KIND_RIGHT_TRIG) begin
         dz = (r.kind == KIND_LEFT_TRIG) ? ltrig_dz : rtrig_dz;
         if (r.lvl <= dz || dz >= 255) return;
         e.id = (r.kind == KIND_LEFT_TRIG) ? ID_LEFT_TRIG : ID_RIGHT_TRIG;
         e.val = q15(0, longint'(r.lvl - dz) * 32768, 255 - dz);
         e.last = 1;
         expected_events.push_back(e);
         return;
      end
      ax = (r.ax < 0) ? -longint'(r.ax) : r.ax;
      ay = (r.ay < 0) ? -longint'(r.ay) : r.ay;
      m0 = int_sqrt(32'(ax * ax + ay * ay));
      dz = (r.kind == KIND_LEFT_STICK) ? lstick_dz : rstick_dz;
      mc = (m0 > 32767) ? 32767 : m0;
      if (m0 <= dz || dz >= 32767) return;
      den = longint'(m0) * (32767 - dz);
      vals[0] = q15(r.ax < 0, ax * (mc - dz) * 32768, den);
      vals[1] = q15(r.ay < 0, ay * (mc - dz) * 32768, den);
      base = (r.kind == KIND_LEFT_STICK) ? ID_LEFT_X : ID_RIGHT_X;
      n = 0;
      for (int i = 0; i < 2; i++) begin
         if (vals[i] != 0) begin
            e.id = base + 3'(i);
            e.val = vals[i];
            e.last = (i == 1 || vals[1] == 0);
            expected_events.push_back(e);
            n++;
         end
      end
   endtask

   // input transfer seen at the rising edge
   always @(posedge clock) begin
      in_taken = !reset && req_valid && !req_stall;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (in_taken) begin
            predict_events(pending_readings.pop_front());
            send_gap = (!calm && $urandom_range(0, 15) == 0) ? $urandom_range(1, 9) : 0;
         end
         if (req_valid && !in_taken) begin
         end else if (send_gap > 0 || hold || pending_readings.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_valid <= 0;
         end else begin
            req_valid <= 1;
            req_kind <= pending_readings[0].kind;
            req_axis_x <= pending_readings[0].ax;
            req_axis_y <= pending_readings[0].ay;
            req_trigger_level <= pending_readings[0].lvl;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            recv_gap = $urandom_range(1, 9) - 1;
            rsp_stall <= 1;
         end else rsp_stall <= 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      axis_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer id=%0d val=%0d last=%0d",
                        rsp_axis_id, rsp_scaled_value, rsp_last_event);
         end else begin
            want = expected_events.pop_front();
            if (want.id !== rsp_axis_id || want.val !== rsp_scaled_value
                || want.last !== rsp_last_event) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp id=%0d val=%0d last=%0d got id=%0d val=%0d last=%0d",
                           want.id, $signed(want.val), want.last,
                           rsp_axis_id, rsp_scaled_value, rsp_last_event);
            end
         end
      end
   end

   task automatic add_reading(kind_type k, int x, int y, int l);
      reading_type r;
      r.kind = k;
      r.ax = 16'(x);
      r.ay = 16'(y);
      r.lvl = 8'(l);
      pending_readings.push_back(r);
   endtask

   task automatic add_random_reading();
      int x, y, mode;
      kind_type k;
      k = kind_type'($urandom_range(0, 3));
      mode = $urandom_range(0, 3);
      x = $urandom_range(0, 65535) - 32768;
      y = $urandom_range(0, 65535) - 32768;
      if (mode == 0) x = 0;
      else if (mode == 1) y = 0;
      add_reading(k, x, y, $urandom_range(0, 255));
   endtask

   task automatic drain();
      wait (pending_readings.size() == 0 && !req_valid);
      wait (expected_events.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [14:0] val);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
      case (idx)
         CSR_LEFT_STICK_DZ:  lstick_dz = val;
         CSR_RIGHT_STICK_DZ: rstick_dz = val;
         CSR_LEFT_TRIG_DZ:   ltrig_dz = val[7:0];
         default:            rtrig_dz = val[7:0];
      endcase
   endtask

   task automatic write_all(logic [14:0] ls, logic [14:0] rs, logic [7:0] lt, logic [7:0] rt);
      write_csr(CSR_LEFT_STICK_DZ, ls);
      write_csr(CSR_RIGHT_STICK_DZ, rs);
      write_csr(CSR_LEFT_TRIG_DZ, {7'd0, lt});
      write_csr(CSR_RIGHT_TRIG_DZ, {7'd0, rt});
   endtask

   initial begin
      lstick_dz = LEFT_STICK_DZ_RESET;
      rstick_dz = RIGHT_STICK_DZ_RESET;
      ltrig_dz = LEFT_TRIG_DZ_RESET;
      rtrig_dz = RIGHT_TRIG_DZ_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: extremes, deadzone gap, overshoot, ignored fields
      add_reading(KIND_LEFT_STICK, 32767, 0, 0);
      add_reading(KIND_LEFT_STICK, -32768, -32768, 255);
      add_reading(KIND_RIGHT_STICK, -32768, 32767, 0);
      add_reading(KIND_RIGHT_STICK, 0, -32768, 0);
      add_reading(KIND_LEFT_STICK, 7849, 0, 0);
      add_reading(KIND_LEFT_STICK, 7850, 0, 0);
      add_reading(KIND_LEFT_STICK, 5550, 5550, 0);
      add_reading(KIND_RIGHT_STICK, 20000, -20000, 0);
      add_reading(KIND_LEFT_STICK, 0, 0, 255);
      add_reading(KIND_LEFT_TRIG, 32767, -1, 255);
      add_reading(KIND_LEFT_TRIG, 0, 0, 30);
      add_reading(KIND_LEFT_TRIG, 0, 0, 31);
      add_reading(KIND_RIGHT_TRIG, -32768, 0, 255);
      add_reading(KIND_RIGHT_TRIG, 0, 0, 0);
      drain();
      write_all(0, 32766, 0, 254);
      add_reading(KIND_LEFT_STICK, 1, 0, 0);
      add_reading(KIND_LEFT_STICK, -1, -1, 0);
      add_reading(KIND_RIGHT_STICK, 32767, 32767, 0);
      add_reading(KIND_RIGHT_STICK, -32768, 0, 0);
      add_reading(KIND_LEFT_TRIG, 0, 0, 255);
      add_reading(KIND_LEFT_TRIG, 0, 0, 1);
      add_reading(KIND_RIGHT_TRIG, 0, 0, 255);
      add_reading(KIND_RIGHT_TRIG, 0, 0, 254);
      drain();
      write_all(15'h7fff, 15'h7fff, 8'hff, 8'hff);
      add_reading(KIND_LEFT_STICK, -32768, -32768, 0);
      add_reading(KIND_RIGHT_STICK, -32768, -32768, 0);
      add_reading(KIND_LEFT_TRIG, 0, 0, 255);
      add_reading(KIND_RIGHT_TRIG, 0, 0, 255);
      drain();
      // random phases over several deadzone settings
      for (int ph = 0; ph < 5; ph++) begin
         write_all(15'($urandom_range(0, 32766)), 15'($urandom_range(0, 20000)),
                   8'($urandom_range(0, 254)), 8'($urandom_range(0, 254)));
         if (ph == 4) calm = 1;
         for (int i = 0; i < 300; i++) begin
            add_random_reading();
            if (ph == 1 && i == 150) begin
               wait (pending_readings.size() == 0 && !req_valid);
               hold = 1;
               wait (expected_events.size() == 0);
               hold = 0;
            end
         end
         drain();
      end
      if (mismatches == 0) $display("tb_gamepad_deadzone_scaler passed");
      else $display("tb_gamepad_deadzone_scaler failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_gamepad_deadzone_scaler failed");
      $finish;
   end
endmodule
